>>> rtl/core/mim_pkg.sv
// Shared types, constants and decode helpers for the MIDI input parser.
package mim_pkg;

  localparam int unsigned SYSEX_DEPTH_DEF = 128;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_LISTEN_CHANNEL   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_VEL_AS_OFF = 1'd1;

  localparam logic [4:0] LISTEN_OMNI  = 5'd0;
  localparam logic [4:0] LISTEN_OFF   = 5'd17;
  localparam logic [4:0] LISTEN_RESET = 5'd1;
  localparam logic       ZERO_VEL_RESET = 1'b1;

  localparam logic [7:0] ST_SYSEX    = 8'hF0;
  localparam logic [7:0] ST_TIMECODE = 8'hF1;
  localparam logic [7:0] ST_SONGPOS  = 8'hF2;
  localparam logic [7:0] ST_SONGSEL  = 8'hF3;
  localparam logic [7:0] ST_TUNE     = 8'hF6;
  localparam logic [7:0] ST_EOX      = 8'hF7;
  localparam logic [7:0] ST_RT_FIRST = 8'hF8;

  typedef enum logic [4:0] {
    KIND_NOTE_OFF     = 5'd0,
    KIND_NOTE_ON      = 5'd1,
    KIND_POLY_AT      = 5'd2,
    KIND_CC           = 5'd3,
    KIND_PROGRAM      = 5'd4,
    KIND_CHAN_AT      = 5'd5,
    KIND_BEND         = 5'd6,
    KIND_SYSEX_DATA   = 5'd7,
    KIND_SYSEX_END    = 5'd8,
    KIND_SYSEX_ABORT  = 5'd9,
    KIND_TIMECODE     = 5'd10,
    KIND_SONGPOS      = 5'd11,
    KIND_SONGSEL      = 5'd12,
    KIND_TUNE         = 5'd13,
    KIND_CLOCK        = 5'd14,
    KIND_START        = 5'd15,
    KIND_CONTINUE     = 5'd16,
    KIND_STOP         = 5'd17,
    KIND_SENSING      = 5'd18,
    KIND_RESET        = 5'd19
  } mim_kind_t;

  typedef struct packed {
    mim_kind_t   kind;
    logic [4:0]  chan;
    logic [6:0]  d1;
    logic [6:0]  d2;
    logic [7:0]  len;
  } mim_item_t;

  typedef struct packed {
    logic      valid;
    mim_kind_t kind;
  } mim_one_t;

  function automatic logic is_chan_status(input logic [7:0] s);
    return s[7] && (s[7:4] != 4'hF);
  endfunction

  function automatic mim_one_t one_kind(input logic [7:0] s);
    mim_one_t r;
    r.valid = 1'b1;
    case (s)
      8'hF6:   r.kind = KIND_TUNE;
      8'hF8:   r.kind = KIND_CLOCK;
      8'hFA:   r.kind = KIND_START;
      8'hFB:   r.kind = KIND_CONTINUE;
      8'hFC:   r.kind = KIND_STOP;
      8'hFE:   r.kind = KIND_SENSING;
      8'hFF:   r.kind = KIND_RESET;
      default: begin
        r.valid = 1'b0;
        r.kind  = KIND_NOTE_OFF;
      end
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/mim_front.sv
// Front end: byte parser with running status, channel filter and config registers.
module mim_front import mim_pkg::*; #(
  parameter int unsigned SYSEX_DEPTH = SYSEX_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [7:0]            rx_byte,
  input  logic                  full,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  item_wr,
  output mim_item_t             item
);

  localparam logic [7:0] SX_LEN = 8'(SYSEX_DEPTH);

  logic [4:0] listen_channel;
  logic       zero_velocity_as_off;

  logic [7:0] running_status, running_status_next;
  logic [7:0] pending_status, pending_status_next;
  logic [7:0] byte_index, byte_index_next;
  logic [7:0] expected_length, expected_length_next;
  logic [6:0] held_data, held_data_next;

  logic       in_fire;
  logic       raw_valid;
  mim_item_t  raw_item;
  mim_one_t   rt;
  logic       start_go, abort_if_quiet;
  logic       fin_go;
  logic [7:0] fin_status;
  logic [6:0] fin_d1, fin_d2;
  logic [7:0] start_len, run_len;
  logic       pass_filter;

  function automatic logic [7:0] msg_len(input logic [7:0] s);
    logic [7:0] r;
    r = 8'd0;
    if (is_chan_status(s)) begin
      r = (s[7:4] == 4'hC || s[7:4] == 4'hD) ? 8'd2 : 8'd3;
    end else if (s == ST_TIMECODE || s == ST_SONGSEL) begin
      r = 8'd2;
    end else if (s == ST_SONGPOS) begin
      r = 8'd3;
    end else if (s == ST_SYSEX) begin
      r = SX_LEN;
    end
    return r;
  endfunction

  assign in_fire   = push && !full;
  assign rt        = one_kind(rx_byte);
  assign start_len = msg_len(rx_byte);
  assign run_len   = msg_len(running_status);

  always_comb begin
    running_status_next  = running_status;
    pending_status_next  = pending_status;
    byte_index_next      = byte_index;
    expected_length_next = expected_length;
    held_data_next       = held_data;
    raw_valid            = 1'b0;
    raw_item             = '{kind: KIND_NOTE_OFF, default: '0};
    start_go             = 1'b0;
    abort_if_quiet       = 1'b0;
    fin_go               = 1'b0;
    fin_status           = 8'd0;
    fin_d1               = 7'd0;
    fin_d2               = 7'd0;

    if (byte_index == 8'd0) begin
      start_go = 1'b1;
    end else if (rx_byte >= ST_RT_FIRST) begin
      if (rt.valid) begin
        raw_valid     = 1'b1;
        raw_item.kind = rt.kind;
      end
    end else if (rx_byte == ST_EOX) begin
      if (pending_status == ST_SYSEX) begin
        raw_valid     = 1'b1;
        raw_item.kind = KIND_SYSEX_END;
        raw_item.len  = byte_index + 8'd1;
      end
      byte_index_next      = 8'd0;
      expected_length_next = 8'd0;
      running_status_next  = 8'd0;
    end else if (rx_byte[7]) begin
      start_go             = 1'b1;
      abort_if_quiet       = (pending_status == ST_SYSEX);
      byte_index_next      = 8'd0;
      expected_length_next = 8'd0;
    end else if (pending_status == ST_SYSEX) begin
      if ({1'b0, byte_index} + 9'd1 >= {1'b0, expected_length}) begin
        byte_index_next      = 8'd0;
        expected_length_next = 8'd0;
        running_status_next  = 8'd0;
        raw_valid            = 1'b1;
        raw_item.kind        = KIND_SYSEX_ABORT;
      end else begin
        byte_index_next = byte_index + 8'd1;
        raw_valid       = 1'b1;
        raw_item.kind   = KIND_SYSEX_DATA;
        raw_item.d1     = rx_byte[6:0];
      end
    end else if (byte_index == 8'd1) begin
      held_data_next = rx_byte[6:0];
      if (expected_length == 8'd2) begin
        fin_go     = 1'b1;
        fin_status = pending_status;
        fin_d1     = rx_byte[6:0];
      end else begin
        byte_index_next = 8'd2;
      end
    end else begin
      fin_go     = 1'b1;
      fin_status = pending_status;
      fin_d1     = held_data;
      fin_d2     = rx_byte[6:0];
    end

    if (start_go) begin
      if (!rx_byte[7]) begin
        if (is_chan_status(running_status)) begin
          pending_status_next = running_status;
          held_data_next      = rx_byte[6:0];
          if (run_len == 8'd2) begin
            fin_go     = 1'b1;
            fin_status = running_status;
            fin_d1     = rx_byte[6:0];
          end else begin
            byte_index_next      = 8'd2;
            expected_length_next = 8'd3;
          end
        end else begin
          byte_index_next      = 8'd0;
          expected_length_next = 8'd0;
          running_status_next  = 8'd0;
        end
      end else if (rt.valid) begin
        if (rx_byte == ST_TUNE) begin
          running_status_next = 8'd0;
        end
        byte_index_next      = 8'd0;
        expected_length_next = 8'd0;
        raw_valid            = 1'b1;
        raw_item.kind        = rt.kind;
      end else if (start_len == 8'd0) begin
        byte_index_next      = 8'd0;
        expected_length_next = 8'd0;
        running_status_next  = 8'd0;
      end else begin
        pending_status_next  = rx_byte;
        expected_length_next = start_len;
        byte_index_next      = 8'd1;
        if (rx_byte == ST_SYSEX) begin
          running_status_next = 8'd0;
        end
      end
    end

    if (fin_go) begin
      byte_index_next      = 8'd0;
      expected_length_next = 8'd0;
      raw_valid            = 1'b1;
      raw_item.d1          = fin_d1;
      raw_item.d2          = fin_d2;
      if (is_chan_status(fin_status)) begin
        raw_item.kind       = mim_kind_t'({2'b00, fin_status[6:4]});
        raw_item.chan       = {1'b0, fin_status[3:0]} + 5'd1;
        running_status_next = fin_status;
      end else begin
        raw_item.kind = (fin_status == ST_TIMECODE) ? KIND_TIMECODE :
                        (fin_status == ST_SONGPOS)  ? KIND_SONGPOS : KIND_SONGSEL;
        running_status_next = 8'd0;
      end
      if (raw_item.kind == KIND_NOTE_ON && fin_d2 == 7'd0 && zero_velocity_as_off) begin
        raw_item.kind = KIND_NOTE_OFF;
      end
    end

    if (abort_if_quiet && !raw_valid) begin
      raw_valid     = 1'b1;
      raw_item      = '{kind: KIND_SYSEX_ABORT, default: '0};
    end
  end

  assign pass_filter = (listen_channel < LISTEN_OFF) &&
                       (raw_item.kind > KIND_BEND || listen_channel == LISTEN_OMNI ||
                        raw_item.chan == listen_channel);
  assign item_wr = in_fire && raw_valid && pass_filter;
  assign item    = raw_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      listen_channel       <= LISTEN_RESET;
      zero_velocity_as_off <= ZERO_VEL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LISTEN_CHANNEL:  listen_channel       <= cfg_data;
        REG_ZERO_VEL_AS_OFF: zero_velocity_as_off <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_status  <= 8'd0;
      pending_status  <= 8'd0;
      byte_index      <= 8'd0;
      expected_length <= 8'd0;
      held_data       <= 7'd0;
    end else if (in_fire) begin
      running_status  <= running_status_next;
      pending_status  <= pending_status_next;
      byte_index      <= byte_index_next;
      expected_length <= expected_length_next;
      held_data       <= held_data_next;
    end
  end

`ifndef SYNTH
  a_len_when_busy: assert property (@(posedge clk) disable iff (rst)
    byte_index != 8'd0 |-> expected_length != 8'd0)
    else $error("message in progress without expected length");

  a_sysex_bound: assert property (@(posedge clk) disable iff (rst)
    (pending_status == ST_SYSEX && byte_index != 8'd0) |-> byte_index < SX_LEN)
    else $error("sysex index past depth");

  a_running_status: assert property (@(posedge clk) disable iff (rst)
    running_status == 8'd0 || is_chan_status(running_status))
    else $error("running status holds a non-channel status");
`endif

endmodule

>>> rtl/core/mim_queue.sv
// Short FIFO of decoded items between the parser and the output stage.
module mim_queue import mim_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_en,
  input  mim_item_t wr_item,
  output logic      full,
  input  logic      rd_en,
  output logic      rd_valid,
  output mim_item_t rd_item
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  mim_item_t        slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign full     = (count == CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = slots[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count past depth");
`endif

endmodule

>>> rtl/core/mim_back.sv
// Back end: expands queued items into result fields and holds the output register.
module mim_back import mim_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  mim_item_t          in_item,
  output logic               in_pop,
  input  logic               pop,
  output logic               empty,
  output logic [4:0]         msg_kind,
  output logic [4:0]         channel_number,
  output logic [6:0]         first_data,
  output logic [6:0]         second_data,
  output logic [13:0]        combined_value,
  output logic signed [13:0] bend_value,
  output logic [7:0]         sysex_length
);

  logic              out_valid;
  mim_kind_t         out_kind;
  logic [13:0]       comb_calc;
  logic signed [13:0] bend_calc;
  logic              load;

  assign load   = in_valid && (!out_valid || pop);
  assign in_pop = load;

  always_comb begin
    comb_calc = 14'd0;
    bend_calc = 14'sd0;
    if (in_item.kind == KIND_BEND || in_item.kind == KIND_SONGPOS) begin
      comb_calc = {in_item.d2, in_item.d1};
    end
    if (in_item.kind == KIND_BEND) begin
      bend_calc = $signed({~in_item.d2[6], in_item.d2[5:0], in_item.d1});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind       <= in_item.kind;
      channel_number <= in_item.chan;
      first_data     <= in_item.d1;
      second_data    <= in_item.d2;
      combined_value <= comb_calc;
      bend_value     <= bend_calc;
      sysex_length   <= in_item.len;
    end
  end

  assign empty    = !out_valid;
  assign msg_kind = out_kind;

`ifndef SYNTH
  a_bend_only: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind != KIND_BEND) |-> bend_value == 14'sd0)
    else $error("bend value set on a non-bend result");
`endif

endmodule

>>> rtl/core/midi_input_parser_top.sv
// Top level of the MIDI input byte-stream parser.
//
// Input channel: one received MIDI byte per transfer on rx_byte, taken when
// push is high and full is low. Result channel: decoded messages, SysEx data,
// end and abort items; the oldest result sits on the ports while empty is
// low and leaves on pop. Config channel: cfg_valid/cfg_ready with cfg_index
// (0 listen channel, 1 zero-velocity note-on as note-off) and cfg_data;
// cfg_ready is always high.
// Throughput: one byte per cycle while full is low. The parser updates its
// message state at the edge that takes a byte and writes any result into a
// QUEUE_DEPTH-entry FIFO at that edge; the output register then loads from the
// FIFO once it is empty or being popped, and the result transfers from it on pop.
// When the receiver stalls, results pile up in the FIFO and the output
// register; full rises once the FIFO holds QUEUE_DEPTH items.
// Reset (rst, synchronous) clears parser state, empties the FIFO and the
// output register, and sets listen channel 1 with zero-velocity mapping on.
module midi_input_parser_top import mim_pkg::*; #(
  parameter int unsigned SYSEX_DEPTH = SYSEX_DEPTH_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            rx_byte,
  output logic                  empty,
  input  logic                  pop,
  output logic [4:0]            msg_kind,
  output logic [4:0]            channel_number,
  output logic [6:0]            first_data,
  output logic [6:0]            second_data,
  output logic [13:0]           combined_value,
  output logic signed [13:0]    bend_value,
  output logic [7:0]            sysex_length,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic      item_wr;
  mim_item_t item;
  logic      q_valid;
  mim_item_t q_item;
  logic      q_pop;

  assign cfg_ready = 1'b1;

  mim_front #(
    .SYSEX_DEPTH (SYSEX_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .rx_byte   (rx_byte),
    .full      (full),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item_wr   (item_wr),
    .item      (item)
  );

  mim_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (item_wr),
    .wr_item  (item),
    .full     (full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_item  (q_item)
  );

  mim_back u_back (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (q_valid),
    .in_item        (q_item),
    .in_pop         (q_pop),
    .pop            (pop),
    .empty          (empty),
    .msg_kind       (msg_kind),
    .channel_number (channel_number),
    .first_data     (first_data),
    .second_data    (second_data),
    .combined_value (combined_value),
    .bend_value     (bend_value),
    .sysex_length   (sysex_length)
  );

endmodule
